### hdl/cutc_pkg.sv
// Shared types, constants and lookup functions for the unix time / calendar converter.
`default_nettype none

package cutc_pkg;

  localparam int unsigned SECS_W   = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned FIELDS_W = SECS_W + YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int unsigned TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int unsigned PAD_W    = TDATA_W - FIELDS_W;

  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned DIVR_W   = 11;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR        = 12'd1970;
  localparam logic [YEAR_W-1:0]  LEAP_BASE_YEAR    = 12'd1968;
  localparam logic [YEAR_W-1:0]  CENTURY_BASE_YEAR = 12'd1900;
  localparam logic [YEAR_W-1:0]  QUAD_CENT_SHIFT   = 12'd3;
  localparam logic [YEAR_W-1:0]  CENTURY_OFFSET    = 12'd19;
  localparam logic [MONTH_W-1:0] MONTH_MAX         = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB         = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_DAY          = 5'd29;
  localparam logic [8:0]         DAYS_PER_YEAR     = 9'd365;
  localparam logic [SECS_W-1:0]  QUAD_OFFSET       = 32'd671;
  localparam logic [SECS_W-1:0]  CORR_ADD_A        = 32'd17;
  localparam logic [SECS_W-1:0]  CORR_ADD_B        = 32'd92;
  localparam logic [DIVR_W-1:0]  LEAP_REM          = 11'd1460;
  localparam logic [1:0]         PASS_LAST         = 2'd3;
  localparam logic [5:0]         MUL_HOUR          = 6'd24;
  localparam logic [5:0]         MUL_MIN           = 6'd60;

  typedef enum logic [2:0] {
    DIV_60,
    DIV_24,
    DIV_1461,
    DIV_25,
    DIV_100,
    DIV_365
  } div_sel_t;

  localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
  localparam logic [31:0] RECIP_60   = 32'(TWO_POW_32 / 33'd60);
  localparam logic [31:0] RECIP_24   = 32'(TWO_POW_32 / 33'd24);
  localparam logic [31:0] RECIP_1461 = 32'(TWO_POW_32 / 33'd1461);
  localparam logic [31:0] RECIP_25   = 32'(TWO_POW_32 / 33'd25);
  localparam logic [31:0] RECIP_100  = 32'(TWO_POW_32 / 33'd100);
  localparam logic [31:0] RECIP_365  = 32'(TWO_POW_32 / 33'd365);

  typedef struct packed {
    logic              start;
    logic [SECS_W-1:0] x;
    div_sel_t          sel;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SECS_W-1:0] q;
    logic [DIVR_W-1:0] r;
  } div_rsp_t;

  typedef struct packed {
    logic               status;
    logic [SECS_W-1:0]  seconds_count_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [HOUR_W-1:0]  hour_out;
    logic [MIN_W-1:0]   minute_out;
    logic [SEC_W-1:0]   second_out;
  } result_t;

  function automatic logic [DIVR_W-1:0] divisor(div_sel_t sel);
    unique case (sel)
      DIV_60:   divisor = 11'd60;
      DIV_24:   divisor = 11'd24;
      DIV_1461: divisor = 11'd1461;
      DIV_25:   divisor = 11'd25;
      DIV_100:  divisor = 11'd100;
      DIV_365:  divisor = 11'd365;
      default:  divisor = 11'd1;
    endcase
  endfunction

  function automatic logic [31:0] recip(div_sel_t sel);
    unique case (sel)
      DIV_60:   recip = RECIP_60;
      DIV_24:   recip = RECIP_24;
      DIV_1461: recip = RECIP_1461;
      DIV_25:   recip = RECIP_25;
      DIV_100:  recip = RECIP_100;
      DIV_365:  recip = RECIP_365;
      default:  recip = '0;
    endcase
  endfunction

  function automatic logic [DOY_W-1:0] days_before(logic [MONTH_W-1:0] idx);
    unique case (idx)
      4'd0:    days_before = 9'd0;
      4'd1:    days_before = 9'd31;
      4'd2:    days_before = 9'd59;
      4'd3:    days_before = 9'd90;
      4'd4:    days_before = 9'd120;
      4'd5:    days_before = 9'd151;
      4'd6:    days_before = 9'd181;
      4'd7:    days_before = 9'd212;
      4'd8:    days_before = 9'd243;
      4'd9:    days_before = 9'd273;
      4'd10:   days_before = 9'd304;
      4'd11:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### hdl/cutc_cdiv.sv
// Shared divide-by-constant unit: reciprocal multiply, back-multiply, one correction step.
`default_nettype none

module cutc_cdiv (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cutc_pkg::div_req_t req,
  output cutc_pkg::div_rsp_t     rsp
);

  logic                               v1;
  logic                               v2;
  logic                               done;
  logic [cutc_pkg::SECS_W-1:0]        x1;
  cutc_pkg::div_sel_t                 sel1;
  logic [2*cutc_pkg::SECS_W-1:0]      prod;
  logic [cutc_pkg::SECS_W-1:0]        x2;
  logic [cutc_pkg::DIVR_W-1:0]        d2;
  logic [cutc_pkg::SECS_W-1:0]        qe2;
  logic [cutc_pkg::SECS_W-1:0]        qd2;
  logic [cutc_pkg::SECS_W-1:0]        rem_raw;
  logic                               fix;
  logic [cutc_pkg::SECS_W-1:0]        q;
  logic [cutc_pkg::DIVR_W-1:0]        r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_comb begin
    rem_raw = x2 - qd2;
    fix     = rem_raw >= 32'(d2);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x1   <= req.x;
      sel1 <= req.sel;
      prod <= 64'(req.x) * 64'(cutc_pkg::recip(req.sel));
    end
    if (v1) begin
      x2  <= x1;
      d2  <= cutc_pkg::divisor(sel1);
      qe2 <= prod[2*cutc_pkg::SECS_W-1:cutc_pkg::SECS_W];
      qd2 <= 32'(prod[2*cutc_pkg::SECS_W-1:cutc_pkg::SECS_W] * 32'(cutc_pkg::divisor(sel1)));
    end
    if (v2) begin
      if (fix) begin
        q <= qe2 + 32'd1;
        r <= cutc_pkg::DIVR_W'(rem_raw - 32'(d2));
      end else begin
        q <= qe2;
        r <= cutc_pkg::DIVR_W'(rem_raw);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;
  assign rsp.r    = r;

endmodule

`default_nettype wire

### hdl/cutc_seq.sv
// Sequencer for encode and decode steps around the shared divide unit.
`default_nettype none

module cutc_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic [cutc_pkg::SECS_W-1:0]  seconds_count_in,
  input  wire logic [cutc_pkg::YEAR_W-1:0]  year_in,
  input  wire logic [cutc_pkg::MONTH_W-1:0] month_in,
  input  wire logic [cutc_pkg::DAY_W-1:0]   day_in,
  input  wire logic [cutc_pkg::HOUR_W-1:0]  hour_in,
  input  wire logic [cutc_pkg::MIN_W-1:0]   minute_in,
  input  wire logic [cutc_pkg::SEC_W-1:0]   second_in,
  output cutc_pkg::div_req_t                div_req,
  input  wire cutc_pkg::div_rsp_t           div_rsp,
  output cutc_pkg::result_t                 res,
  output logic                              res_valid,
  input  wire logic                         res_take
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENC_DIV,
    ST_ENC_HOUR,
    ST_ENC_MIN,
    ST_ENC_SEC,
    ST_DEC_SEC,
    ST_DEC_MIN,
    ST_DEC_HOUR,
    ST_DEC_QUAD,
    ST_DEC_CA,
    ST_DEC_CB,
    ST_DEC_REM,
    ST_DEC_YEAR,
    ST_DEC_LEAP,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [1:0]                      pass;
  logic [cutc_pkg::YEAR_W-1:0]     yr;
  logic [cutc_pkg::MONTH_W-1:0]    mo;
  logic [cutc_pkg::DAY_W-1:0]      dd;
  logic [cutc_pkg::HOUR_W-1:0]     hh;
  logic [cutc_pkg::MIN_W-1:0]      mi;
  logic [cutc_pkg::SEC_W-1:0]      ss;
  logic [cutc_pkg::SECS_W-1:0]     acc;
  logic [cutc_pkg::DAYS_W-1:0]     days;
  logic [cutc_pkg::DAYS_W-1:0]     quads;
  logic [cutc_pkg::DAYS_W-1:0]     corr;
  logic [cutc_pkg::DAYS_W-1:0]     ca;
  logic [cutc_pkg::DIVR_W-1:0]     rem;
  logic [cutc_pkg::DOY_W-1:0]      dy;

  logic                            enc_bad;
  logic [cutc_pkg::YEAR_W-1:0]     c100;
  logic [cutc_pkg::YEAR_W-1:0]     c_cent;
  logic [cutc_pkg::YEAR_W-1:0]     yrs;
  logic [20:0]                     yr_days;
  logic [cutc_pkg::SECS_W-1:0]     enc_days;
  logic [cutc_pkg::SECS_W-1:0]     enc_leaps;
  logic                            enc_leapday;
  logic [cutc_pkg::SECS_W-1:0]     enc_total;
  logic [5:0]                      mac_k;
  logic [5:0]                      mac_add;
  logic [cutc_pkg::SECS_W-1:0]     mac;
  logic [cutc_pkg::DAYS_W-1:0]     next_corr;
  logic [cutc_pkg::DAYS_W-1:0]     base;
  logic [cutc_pkg::YEAR_W-1:0]     yy_new;
  logic [cutc_pkg::MONTH_W-1:0]    mm_calc;
  logic [cutc_pkg::DAY_W-1:0]      dm_calc;
  logic                            leap_ok;

  always_comb begin
    enc_bad     = (month_in == '0) || (month_in > cutc_pkg::MONTH_MAX) ||
                  (year_in < cutc_pkg::EPOCH_YEAR);
    c100        = div_rsp.q[cutc_pkg::YEAR_W-1:0];
    c_cent      = c100 + cutc_pkg::CENTURY_OFFSET;
    yrs         = yr - cutc_pkg::EPOCH_YEAR;
    yr_days     = 21'(yrs) * 21'(cutc_pkg::DAYS_PER_YEAR);
    enc_days    = 32'(yr_days) + 32'(cutc_pkg::days_before(mo - 4'd1)) + 32'(dd);
    enc_leaps   = 32'((yr - cutc_pkg::LEAP_BASE_YEAR) >> 2) - 32'(c100) +
                  32'((c100 + cutc_pkg::QUAD_CENT_SHIFT) >> 2);
    enc_leapday = (mo <= cutc_pkg::MONTH_FEB) && (yr[1:0] == 2'b00) &&
                  ((div_rsp.r != '0) || (c_cent[1:0] == 2'b00));
    enc_total   = enc_days + enc_leaps - 32'(enc_leapday) - 32'd1;

    mac_k   = cutc_pkg::MUL_MIN;
    mac_add = ss;
    if (state == ST_ENC_HOUR) begin
      mac_k   = cutc_pkg::MUL_HOUR;
      mac_add = 6'(hh);
    end else if (state == ST_ENC_MIN) begin
      mac_add = mi;
    end
    mac = acc * 32'(mac_k) + 32'(mac_add);

    next_corr = ca - div_rsp.q[cutc_pkg::DAYS_W-1:0];
    base      = days - quads + corr;
    yy_new    = cutc_pkg::EPOCH_YEAR + div_rsp.q[cutc_pkg::YEAR_W-1:0];

    mm_calc = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (dy >= cutc_pkg::days_before(4'(i))) begin
        mm_calc = mm_calc + 4'd1;
      end
    end
    dm_calc = 5'(dy - cutc_pkg::days_before(mm_calc - 4'd1) + 9'd1);
    leap_ok = (div_rsp.r != '0) || (div_rsp.q[1:0] == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res <= '0;
            yr  <= year_in;
            mo  <= month_in;
            dd  <= day_in;
            hh  <= hour_in;
            mi  <= minute_in;
            ss  <= second_in;
            if (req_type == cutc_pkg::REQ_DECODE) begin
              div_req.start <= 1'b1;
              div_req.x     <= seconds_count_in;
              div_req.sel   <= cutc_pkg::DIV_60;
              state         <= ST_DEC_SEC;
            end else if (enc_bad) begin
              res.status <= cutc_pkg::STATUS_ERR;
              state      <= ST_DONE;
            end else begin
              div_req.start <= 1'b1;
              div_req.x     <= 32'(year_in - cutc_pkg::CENTURY_BASE_YEAR);
              div_req.sel   <= cutc_pkg::DIV_100;
              state         <= ST_ENC_DIV;
            end
          end
        end
        ST_ENC_DIV: begin
          if (div_rsp.done) begin
            acc   <= enc_total;
            state <= ST_ENC_HOUR;
          end
        end
        ST_ENC_HOUR: begin
          acc   <= mac;
          state <= ST_ENC_MIN;
        end
        ST_ENC_MIN: begin
          acc   <= mac;
          state <= ST_ENC_SEC;
        end
        ST_ENC_SEC: begin
          res.seconds_count_out <= mac;
          state                 <= ST_DONE;
        end
        ST_DEC_SEC: begin
          if (div_rsp.done) begin
            res.second_out <= cutc_pkg::SEC_W'(div_rsp.r);
            div_req.start  <= 1'b1;
            div_req.x      <= div_rsp.q;
            div_req.sel    <= cutc_pkg::DIV_60;
            state          <= ST_DEC_MIN;
          end
        end
        ST_DEC_MIN: begin
          if (div_rsp.done) begin
            res.minute_out <= cutc_pkg::MIN_W'(div_rsp.r);
            div_req.start  <= 1'b1;
            div_req.x      <= div_rsp.q;
            div_req.sel    <= cutc_pkg::DIV_24;
            state          <= ST_DEC_HOUR;
          end
        end
        ST_DEC_HOUR: begin
          if (div_rsp.done) begin
            res.hour_out  <= cutc_pkg::HOUR_W'(div_rsp.r);
            days          <= div_rsp.q[cutc_pkg::DAYS_W-1:0];
            corr          <= '0;
            pass          <= '0;
            div_req.start <= 1'b1;
            div_req.x     <= 32'(div_rsp.q[cutc_pkg::DAYS_W-1:0]) + cutc_pkg::QUAD_OFFSET;
            div_req.sel   <= cutc_pkg::DIV_1461;
            state         <= ST_DEC_QUAD;
          end
        end
        ST_DEC_QUAD: begin
          if (div_rsp.done) begin
            quads         <= div_rsp.q[cutc_pkg::DAYS_W-1:0];
            rem           <= div_rsp.r;
            div_req.start <= 1'b1;
            div_req.x     <= div_rsp.q + cutc_pkg::CORR_ADD_A;
            div_req.sel   <= cutc_pkg::DIV_25;
            state         <= ST_DEC_CA;
          end
        end
        ST_DEC_CA: begin
          if (div_rsp.done) begin
            ca            <= div_rsp.q[cutc_pkg::DAYS_W-1:0];
            div_req.start <= 1'b1;
            div_req.x     <= 32'(quads) + cutc_pkg::CORR_ADD_B;
            div_req.sel   <= cutc_pkg::DIV_100;
            state         <= ST_DEC_CB;
          end
        end
        ST_DEC_CB: begin
          if (div_rsp.done) begin
            div_req.start <= 1'b1;
            if (next_corr == corr) begin
              div_req.x   <= 32'(base);
              div_req.sel <= cutc_pkg::DIV_365;
              state       <= ST_DEC_YEAR;
            end else begin
              corr        <= next_corr;
              div_req.x   <= 32'(days) + cutc_pkg::QUAD_OFFSET + 32'(next_corr);
              div_req.sel <= cutc_pkg::DIV_1461;
              if (pass == cutc_pkg::PASS_LAST) begin
                state <= ST_DEC_REM;
              end else begin
                pass  <= pass + 2'd1;
                state <= ST_DEC_QUAD;
              end
            end
          end
        end
        ST_DEC_REM: begin
          if (div_rsp.done) begin
            rem           <= div_rsp.r;
            div_req.start <= 1'b1;
            div_req.x     <= 32'(base);
            div_req.sel   <= cutc_pkg::DIV_365;
            state         <= ST_DEC_YEAR;
          end
        end
        ST_DEC_YEAR: begin
          if (div_rsp.done) begin
            res.year_out  <= yy_new;
            dy            <= div_rsp.r[cutc_pkg::DOY_W-1:0];
            div_req.start <= 1'b1;
            div_req.x     <= 32'(yy_new);
            div_req.sel   <= cutc_pkg::DIV_100;
            state         <= ST_DEC_LEAP;
          end
        end
        ST_DEC_LEAP: begin
          if (div_rsp.done) begin
            if (leap_ok && (rem == cutc_pkg::LEAP_REM)) begin
              res.month_out <= cutc_pkg::MONTH_FEB;
              res.day_out   <= cutc_pkg::LEAP_DAY;
            end else begin
              res.month_out <= mm_calc;
              res.day_out   <= dm_calc;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

`default_nettype wire

### hdl/calendar_unix_time_convert_core.sv
// Top level of the unix time / calendar converter: ports, field unpacking, output register.
//
// Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one request word; s_tuser
// selects encode (0: calendar fields to seconds count) or decode (1: seconds count to
// calendar fields). Master channel (m_tvalid/m_tready/m_tdata/m_tuser) returns exactly
// one result word per request, in order; m_tuser is the error status.
// One request is in work at a time; s_tready is low from accept until its result is
// moved into the output register. The work runs through one shared divide-by-constant
// unit. Steps from accept to m_tvalid high:
//   bad month or year:   no division; the error word is loaded
//   encode:              one division, three multiply-add steps, one load
//   decode:              seconds, minutes and hours divisions, 1 to 4 passes of the
//                        leap-day correction (plus a remainder division when four
//                        passes do not settle), then year and leap-year divisions
// s_tready rises as the output register loads, in the same cycle as m_tvalid.
// The output register holds a finished word while m_tready is low; the next request is
// taken meanwhile and waits at its end until the register frees up.
// Reset (rst, synchronous, active high) empties the output register and returns the
// sequencer to idle; no request or result survives it.
`default_nettype none

module calendar_unix_time_convert_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // seconds_count_in, year_in, month_in, day_in, hour_in, minute_in, second_in, zero pad
  input  wire logic [cutc_pkg::TDATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // seconds_count_out, year_out, month_out, day_out, hour_out, minute_out, second_out, pad
  output logic [cutc_pkg::TDATA_W-1:0]       m_tdata,
  // status
  output logic                               m_tuser
);

  localparam int unsigned YEAR_LO  = cutc_pkg::SECS_W;
  localparam int unsigned MONTH_LO = YEAR_LO + cutc_pkg::YEAR_W;
  localparam int unsigned DAY_LO   = MONTH_LO + cutc_pkg::MONTH_W;
  localparam int unsigned HOUR_LO  = DAY_LO + cutc_pkg::DAY_W;
  localparam int unsigned MIN_LO   = HOUR_LO + cutc_pkg::HOUR_W;
  localparam int unsigned SEC_LO   = MIN_LO + cutc_pkg::MIN_W;

  cutc_pkg::div_req_t div_req;
  cutc_pkg::div_rsp_t div_rsp;
  cutc_pkg::result_t  res;
  logic               res_valid;
  logic               take;

  assign take = !m_tvalid || m_tready;

  cutc_cdiv u_cdiv (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cutc_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .req_type         (s_tuser),
    .seconds_count_in (s_tdata[cutc_pkg::SECS_W-1:0]),
    .year_in          (s_tdata[YEAR_LO +: cutc_pkg::YEAR_W]),
    .month_in         (s_tdata[MONTH_LO +: cutc_pkg::MONTH_W]),
    .day_in           (s_tdata[DAY_LO +: cutc_pkg::DAY_W]),
    .hour_in          (s_tdata[HOUR_LO +: cutc_pkg::HOUR_W]),
    .minute_in        (s_tdata[MIN_LO +: cutc_pkg::MIN_W]),
    .second_in        (s_tdata[SEC_LO +: cutc_pkg::SEC_W]),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .res              (res),
    .res_valid        (res_valid),
    .res_take         (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && take) begin
      m_tdata <= {{cutc_pkg::PAD_W{1'b0}}, res.second_out, res.minute_out, res.hour_out,
                  res.day_out, res.month_out, res.year_out, res.seconds_count_out};
      m_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire

### hdl/cutc_chk.sv
// Port-level checker for the converter and its bind to the top level.
`default_nettype none

module cutc_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [cutc_pkg::TDATA_W-1:0] m_tdata,
  input wire logic                         m_tuser
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a request is in work");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == cutc_pkg::STATUS_ERR) |-> (m_tdata == '0))
    else $error("error word carries nonzero fields");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[cutc_pkg::SECS_W-1:0] == '0) ||
                 (m_tdata[cutc_pkg::FIELDS_W-1:cutc_pkg::SECS_W] == '0))
    else $error("word carries both a count and calendar fields");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind calendar_unix_time_convert_core cutc_chk u_cutc_chk (.*);

`default_nettype wire
